@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset (active-low reset).
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ src/mbs_pkg.sv @@
package mbs_pkg;

	localparam int SEG_BITS = 32;

	// Result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = 2;
	localparam int RES_CW    = 3;

	// Characters of interest
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_TICK  = 8'h60;

	localparam logic [23:0] FENCE_PREFIX = {CH_TICK, CH_TICK, CH_TICK};
	localparam logic [1:0]  PREFIX_LEN_MAX = 2'd3;

	typedef struct packed {
		logic [SEG_BITS-1:0] bstart;
		logic [SEG_BITS-1:0] bstop;
		logic [SEG_BITS-1:0] cstart;
		logic [SEG_BITS-1:0] cstop;
		logic                run_last;
	} seg_t;

endpackage

@@ src/mbs_byte_if.sv @@
interface mbs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       doc_last;

	modport source (output valid, output data_byte, output doc_last, input ready);
	modport sink (input valid, input data_byte, input doc_last, output ready);
endinterface

@@ src/mbs_seg_if.sv @@
interface mbs_seg_if;
	logic                         valid;
	logic                         ready;
	logic [mbs_pkg::SEG_BITS-1:0] seg_byte_start;
	logic [mbs_pkg::SEG_BITS-1:0] seg_byte_end;
	logic [mbs_pkg::SEG_BITS-1:0] seg_char_start;
	logic [mbs_pkg::SEG_BITS-1:0] seg_char_end;
	logic                         run_last;

	modport source (output valid, output seg_byte_start, output seg_byte_end,
		output seg_char_start, output seg_char_end, output run_last, input ready);
	modport sink (input valid, input seg_byte_start, input seg_byte_end,
		input seg_char_start, input seg_char_end, input run_last, output ready);
endinterface

@@ src/mbs_res_fifo.sv @@
`include "assert_macros.svh"

module mbs_res_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_num,
	input  mbs_pkg::seg_t              push_d0,
	input  mbs_pkg::seg_t              push_d1,
	output logic [mbs_pkg::RES_CW-1:0] free_cnt,
	mbs_seg_if.source                  seg_out
);
	import mbs_pkg::*;

	seg_t              mem_q [RES_DEPTH];
	logic [RES_AW-1:0] rd_ptr_q;
	logic [RES_AW-1:0] wr_ptr_q;
	logic [RES_CW-1:0] count_q;
	logic              pop;

	assign pop      = seg_out.valid && seg_out.ready;
	assign free_cnt = RES_CW'(RES_DEPTH) - count_q;

	always_ff @(posedge clk) begin
		if (push_num != 2'd0) begin
			mem_q[wr_ptr_q] <= push_d0;
		end
		if (push_num == 2'd2) begin
			mem_q[wr_ptr_q + RES_AW'(1)] <= push_d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_AW'(push_num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_AW'(1);
			end
			count_q <= count_q + RES_CW'(push_num) - RES_CW'(pop);
		end
	end

	assign seg_out.valid          = (count_q != '0);
	assign seg_out.seg_byte_start = mem_q[rd_ptr_q].bstart;
	assign seg_out.seg_byte_end   = mem_q[rd_ptr_q].bstop;
	assign seg_out.seg_char_start = mem_q[rd_ptr_q].cstart;
	assign seg_out.seg_char_end   = mem_q[rd_ptr_q].cstop;
	assign seg_out.run_last       = mem_q[rd_ptr_q].run_last;

	`ASSERT_RST(a_count_bound, clk, arst_n, count_q <= RES_CW'(RES_DEPTH), "queue overfilled")
	`ASSERT_RST(a_push_room, clk, arst_n, RES_CW'(push_num) <= free_cnt, "push without room")
	`ASSERT_RST(a_push_num, clk, arst_n, push_num != 2'd3, "more than two pushed")

endmodule

@@ src/markdown_block_segmenter.sv @@
// Markdown block segmenter: takes one document byte per transaction and returns line-based
// segments (byte and codepoint start/end offsets), zero to two per byte, in document order.
// A byte is registered on entry, classified from that register against the line and segment
// state, and its results go into a four-entry result queue; one byte per cycle is sustained
// as long as the queue keeps two free entries, which the segment consumer sets by taking
// results. Offsets saturate at 2^OFFSET_BITS-1 and are reported as their low 32 bits; the
// byte marked doc_last flushes any open segment and returns the block to its reset state.
`include "assert_macros.svh"

module markdown_block_segmenter #(
	parameter int OFFSET_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	mbs_byte_if.sink  byte_in,
	mbs_seg_if.source seg_out
);
	import mbs_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

	// Input register
	logic [7:0] data_s1;
	logic       last_s1;
	logic       valid_s1;

	// Document state
	logic [OFFSET_BITS-1:0] byte_pos_q, char_pos_q;
	logic [OFFSET_BITS-1:0] open_byte_q, open_char_q;
	logic [OFFSET_BITS-1:0] line_byte_q, line_char_q;
	logic                   fence_open_q, segment_open_q;
	logic [23:0]            line_prefix_q;
	logic [1:0]             line_len_q;
	logic                   line_blank_q;

	logic [RES_CW-1:0] free_cnt;
	logic              in_fire, s1_fire;

	logic [OFFSET_BITS-1:0] end_b, end_c;
	logic [23:0]            prefix_n;
	logic [1:0]             len_n;
	logic                   blank_n, eol;
	logic                   is_fence, is_heading, is_list;
	logic                   fence_n, seg_n;
	logic [OFFSET_BITS-1:0] open_b_n, open_c_n;
	logic                   a_v, b_v;
	logic [OFFSET_BITS-1:0] b_sb, b_sc;
	seg_t                   seg_a, seg_b, push_d0, push_d1;
	logic [1:0]             push_num;

	assign s1_fire       = valid_s1 && (free_cnt >= RES_CW'(2));
	assign byte_in.ready = !valid_s1 || s1_fire;
	assign in_fire       = byte_in.valid && byte_in.ready;

	always_comb begin
		end_b = (byte_pos_q == OFS_MAX) ? byte_pos_q : byte_pos_q + OFFSET_BITS'(1);
		// continuation bytes do not start a codepoint
		if (data_s1[7:6] != 2'b10 && char_pos_q != OFS_MAX) begin
			end_c = char_pos_q + OFFSET_BITS'(1);
		end else begin
			end_c = char_pos_q;
		end

		prefix_n = line_prefix_q;
		len_n    = line_len_q;
		if (data_s1 != CH_NL) begin
			unique case (line_len_q)
				2'd0: prefix_n[7:0]   = data_s1;
				2'd1: prefix_n[15:8]  = data_s1;
				2'd2: prefix_n[23:16] = data_s1;
				default: prefix_n = line_prefix_q;
			endcase
			if (line_len_q != PREFIX_LEN_MAX) begin
				len_n = line_len_q + 2'd1;
			end
		end
		blank_n  = line_blank_q &&
			(data_s1 == CH_SPACE || data_s1 == CH_TAB || data_s1 == CH_NL);
		eol      = (data_s1 == CH_NL) || last_s1;

		is_fence   = (len_n == PREFIX_LEN_MAX) && (prefix_n == FENCE_PREFIX);
		is_heading = (len_n != 2'd0) && (prefix_n[7:0] == CH_HASH);
		is_list    = (len_n >= 2'd2) && (prefix_n[15:8] == CH_SPACE) &&
			(prefix_n[7:0] == CH_DASH || prefix_n[7:0] == CH_STAR ||
			 prefix_n[7:0] == CH_PLUS);

		fence_n  = fence_open_q;
		seg_n    = segment_open_q;
		open_b_n = open_byte_q;
		open_c_n = open_char_q;
		// a: open segment closed at the line start; b: a segment ending at this byte
		a_v  = 1'b0;
		b_v  = 1'b0;
		b_sb = open_byte_q;
		b_sc = open_char_q;

		if (eol) begin
			priority if (is_fence && !fence_open_q) begin
				a_v      = segment_open_q;
				open_b_n = line_byte_q;
				open_c_n = line_char_q;
				seg_n    = 1'b1;
				fence_n  = 1'b1;
			end else if (is_fence) begin
				b_v     = 1'b1;
				seg_n   = 1'b0;
				fence_n = 1'b0;
			end else if (fence_open_q) begin
				seg_n = segment_open_q;
			end else if (blank_n) begin
				b_v   = segment_open_q;
				seg_n = 1'b0;
			end else if (is_heading || is_list) begin
				a_v   = segment_open_q;
				b_v   = 1'b1;
				b_sb  = line_byte_q;
				b_sc  = line_char_q;
				seg_n = 1'b0;
			end else if (!segment_open_q) begin
				open_b_n = line_byte_q;
				open_c_n = line_char_q;
				seg_n    = 1'b1;
			end else begin
				seg_n = 1'b1;
			end
			// document end flushes whatever is still open
			if (last_s1 && seg_n) begin
				b_v  = 1'b1;
				b_sb = open_b_n;
				b_sc = open_c_n;
			end
		end

		seg_a.bstart   = SEG_BITS'(open_byte_q);
		seg_a.bstop    = SEG_BITS'(line_byte_q);
		seg_a.cstart   = SEG_BITS'(open_char_q);
		seg_a.cstop    = SEG_BITS'(line_char_q);
		seg_a.run_last = !b_v;

		seg_b.bstart   = SEG_BITS'(b_sb);
		seg_b.bstop    = SEG_BITS'(end_b);
		seg_b.cstart   = SEG_BITS'(b_sc);
		seg_b.cstop    = SEG_BITS'(end_c);
		seg_b.run_last = 1'b1;

		push_d0  = a_v ? seg_a : seg_b;
		push_d1  = seg_b;
		push_num = s1_fire ? (2'(a_v) + 2'(b_v)) : 2'd0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.doc_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			byte_pos_q     <= '0;
			char_pos_q     <= '0;
			open_byte_q    <= '0;
			open_char_q    <= '0;
			line_byte_q    <= '0;
			line_char_q    <= '0;
			fence_open_q   <= 1'b0;
			segment_open_q <= 1'b0;
			line_prefix_q  <= '0;
			line_len_q     <= '0;
			line_blank_q   <= 1'b1;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				if (last_s1) begin
					byte_pos_q     <= '0;
					char_pos_q     <= '0;
					open_byte_q    <= '0;
					open_char_q    <= '0;
					line_byte_q    <= '0;
					line_char_q    <= '0;
					fence_open_q   <= 1'b0;
					segment_open_q <= 1'b0;
					line_prefix_q  <= '0;
					line_len_q     <= '0;
					line_blank_q   <= 1'b1;
				end else begin
					byte_pos_q     <= end_b;
					char_pos_q     <= end_c;
					open_byte_q    <= open_b_n;
					open_char_q    <= open_c_n;
					fence_open_q   <= fence_n;
					segment_open_q <= seg_n;
					if (eol) begin
						line_byte_q   <= end_b;
						line_char_q   <= end_c;
						line_prefix_q <= '0;
						line_len_q    <= '0;
						line_blank_q  <= 1'b1;
					end else begin
						line_prefix_q <= prefix_n;
						line_len_q    <= len_n;
						line_blank_q  <= blank_n;
					end
				end
			end
		end
	end

	mbs_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_num (push_num),
		.push_d0  (push_d0),
		.push_d1  (push_d1),
		.free_cnt (free_cnt),
		.seg_out  (seg_out)
	);

	`ASSERT_CLK(a_fence_in_seg, clk, fence_open_q |-> segment_open_q, "fence with no segment")
	`ASSERT_RST(a_doc_end_clear, clk, arst_n, s1_fire && last_s1 |=> byte_pos_q == '0, "doc kept")
	`ASSERT_RST(a_close_order, clk, arst_n, s1_fire && a_v |-> open_byte_q <= line_byte_q, "order")
	`ASSERT_RST(a_in_reg_load, clk, arst_n, in_fire |=> valid_s1, "accepted byte not held")

endmodule
